// File: design/atg_pkg.sv
// Shared constants and helpers for the tone map and gamma quantize block.
package atg_pkg;

  localparam int DEF_LUT_ADDR_BITS = 10;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int PIX_W             = 24;
  localparam int BYTE_W            = 8;
  // Width that holds the curve numerator and denominator (up to ~252 * 2^48).
  localparam int CURVE_W           = 2 * PIX_W + 10;
  localparam int BIG_W             = 192;

  // Filmic curve coefficients, scaled by 100.
  localparam int NUM_SQ  = 251;
  localparam int NUM_LIN = 3;
  localparam int DEN_SQ  = 243;
  localparam int DEN_LIN = 59;
  localparam int DEN_C   = 14;

  // Gamma exponent 1/2.2 = 5/11.
  localparam int GAM_NUM = 5;
  localparam int GAM_DEN = 11;
  localparam int BYTE_MAX = 255;

  // Return base^e * k^ek as a wide integer (elaboration-time use).
  function automatic logic [BIG_W-1:0] big_pow(input int base, input int e,
                                               input int k, input int ek);
    logic [BIG_W-1:0] acc;
    acc = BIG_W'(1);
    for (int i = 0; i < e; i++) acc = acc * BIG_W'(base);
    for (int i = 0; i < ek; i++) acc = acc * BIG_W'(k);
    return acc;
  endfunction

endpackage

// File: design/atg_if.sv
// Pixel stream interfaces: linear HDR input and display byte output.
interface atg_in_if;
  logic                     valid;
  logic                     ready;
  logic [atg_pkg::PIX_W-1:0] red_in;
  logic [atg_pkg::PIX_W-1:0] green_in;
  logic [atg_pkg::PIX_W-1:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface atg_out_if;
  logic                      valid;
  logic                      ready;
  logic [atg_pkg::BYTE_W-1:0] red_out;
  logic [atg_pkg::BYTE_W-1:0] green_out;
  logic [atg_pkg::BYTE_W-1:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface

// File: design/atg_channel.sv
// One color channel: filmic curve, bit-per-stage divider, gamma ROM.
module atg_channel #(
  parameter int GAMMA_LUT_ADDR_BITS = atg_pkg::DEF_LUT_ADDR_BITS,
  parameter int FRAC_BITS           = atg_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [atg_pkg::PIX_W-1:0]  pix_in,
  output logic [atg_pkg::BYTE_W-1:0] byte_out
);

  localparam int A     = GAMMA_LUT_ADDR_BITS;
  localparam int F     = FRAC_BITS;
  localparam int W     = atg_pkg::CURVE_W;
  localparam int LUT   = 1 << A;
  localparam int M     = LUT - 1;
  localparam int PW    = F + 1 + A + 1;
  localparam logic [32:0] LIM = (33'd256 << F) - 33'd1;
  localparam logic [W-1:0] D_CONST = W'(atg_pkg::DEN_C) << (2 * F);

  // Gamma ROM: largest n with (n/255)^11 <= (a/M)^5.
  function automatic logic [LUT*8-1:0] build_rom();
    logic [LUT*8-1:0]           rom;
    logic [atg_pkg::BIG_W-1:0]  rhs;
    logic [7:0]                 lo;
    logic [7:0]                 cand;
    rom = '0;
    for (int a = 0; a < LUT; a++) begin
      rhs = atg_pkg::big_pow(a, atg_pkg::GAM_NUM, atg_pkg::BYTE_MAX, atg_pkg::GAM_DEN);
      lo = 8'd0;
      for (int b = 7; b >= 0; b--) begin
        cand = lo | (8'd1 << b);
        if (atg_pkg::big_pow(int'(cand), atg_pkg::GAM_DEN, M, atg_pkg::GAM_NUM) <= rhs)
          lo = cand;
      end
      rom[a*8 +: 8] = lo;
    end
    return rom;
  endfunction

  localparam logic [LUT*8-1:0] GAMMA_ROM = build_rom();

  logic [atg_pkg::PIX_W-1:0]   x1_r, x2_r;
  logic [2*atg_pkg::PIX_W-1:0] sq2_r;
  logic [W-1:0]                r_r [0:F];
  logic [W-1:0]                d_r [0:F];
  logic [F-1:0]                v_r [1:F];
  logic                        sat_r [1:F];
  logic [A-1:0]                addr_r;
  logic [atg_pkg::BYTE_W-1:0]  byte_r;

  logic [W-1:0] xs2;
  logic [W-1:0] sqw2;
  logic [F:0]   v_full;
  logic [PW-1:0] prod;
  logic [A:0]   addr_wide;

  // Saturate radiance above the Q8.F range.
  always_ff @(posedge clk) begin
    if (en) begin
      if ({9'd0, pix_in} > LIM) x1_r <= LIM[atg_pkg::PIX_W-1:0];
      else                      x1_r <= pix_in;
    end
  end

  // Square the radiance.
  always_ff @(posedge clk) begin
    if (en) begin
      sq2_r <= x1_r * x1_r;
      x2_r  <= x1_r;
    end
  end

  // Form numerator and denominator.
  assign xs2  = W'(x2_r) << F;
  assign sqw2 = W'(sq2_r);
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= W'(atg_pkg::NUM_SQ) * sqw2 + W'(atg_pkg::NUM_LIN) * xs2;
      d_r[0] <= W'(atg_pkg::DEN_SQ) * sqw2 + W'(atg_pkg::DEN_LIN) * xs2 + D_CONST;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < F; k++) begin : g_div
    logic         sat_in;
    logic [F-1:0] v_in;
    logic [W-1:0] r_sh;
    logic         ge;
    if (k == 0) begin : g_first
      assign sat_in = r_r[0] >= d_r[0];
      assign v_in   = '0;
    end else begin : g_rest
      assign sat_in = sat_r[k];
      assign v_in   = v_r[k];
    end
    assign r_sh = {r_r[k][W-2:0], 1'b0};
    assign ge   = r_sh >= d_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= ge ? r_sh - d_r[k] : r_sh;
        d_r[k+1]   <= d_r[k];
        v_r[k+1]   <= {v_in[F-2:0], ge};
        sat_r[k+1] <= sat_in;
      end
    end
  end

  // Scale the curve value to a ROM address, rounding half up.
  assign v_full    = sat_r[F] ? ((F+1)'(1) << F) : {1'b0, v_r[F]};
  assign prod      = (PW'(v_full) << A) - PW'(v_full) + (PW'(1) << (F - 1));
  assign addr_wide = prod[F +: A+1];
  always_ff @(posedge clk) begin
    if (en) begin
      if (addr_wide > (A+1)'(M)) addr_r <= A'(M);
      else                       addr_r <= addr_wide[A-1:0];
    end
  end

  // Look up the display byte.
  always_ff @(posedge clk) begin
    if (en) byte_r <= GAMMA_ROM[addr_r*8 +: 8];
  end

  assign byte_out = byte_r;

endmodule

// File: design/aces_tonemap_gamma_quantize_unit.sv
// Top level: three channel pipelines under one valid/stall control.
// Takes one linear RGB pixel (unsigned, FRAC_BITS fraction bits) per clock
// while the output is taken and returns one RGB888 pixel for each. Each
// channel runs the filmic curve x(2.51x+0.03)/(x(2.43x+0.59)+0.14) in exact
// integers, divides one quotient bit per pipeline stage, rounds to a gamma ROM
// address and reads the 1/2.2 gamma byte. Pipeline depth grows with the divider
// stages; throughput is one pixel per cycle while the output is taken. The
// whole pipeline stalls only when the last stage holds a pixel not yet taken.
module aces_tonemap_gamma_quantize_unit #(
  parameter int GAMMA_LUT_ADDR_BITS = atg_pkg::DEF_LUT_ADDR_BITS,
  parameter int FRAC_BITS           = atg_pkg::DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  atg_in_if.sink           in_pix,
  atg_out_if.source        out_pix
);

  localparam int LAT = FRAC_BITS + 5;

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;
  logic           en;

  // Advance everything unless the last stage is held.
  assign en            = !vld_r[LAT-1] || out_pix.ready;
  assign in_pix.ready  = en;
  assign out_pix.valid = vld_r[LAT-1];

  // Shift valid bits alongside the data.
  assign vld_nxt = en ? {vld_r[LAT-2:0], in_pix.valid} : vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  atg_channel #(.GAMMA_LUT_ADDR_BITS(GAMMA_LUT_ADDR_BITS), .FRAC_BITS(FRAC_BITS))
    u_red (.clk(clk), .en(en), .pix_in(in_pix.red_in), .byte_out(out_pix.red_out));
  atg_channel #(.GAMMA_LUT_ADDR_BITS(GAMMA_LUT_ADDR_BITS), .FRAC_BITS(FRAC_BITS))
    u_green (.clk(clk), .en(en), .pix_in(in_pix.green_in), .byte_out(out_pix.green_out));
  atg_channel #(.GAMMA_LUT_ADDR_BITS(GAMMA_LUT_ADDR_BITS), .FRAC_BITS(FRAC_BITS))
    u_blue (.clk(clk), .en(en), .pix_in(in_pix.blue_in), .byte_out(out_pix.blue_out));

  // A transfer in enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> vld_r[0])
    else $error("accepted pixel did not enter pipeline");

  // Never stall with an empty last stage.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_pix.valid |-> in_pix.ready)
    else $error("input stalled while output empty");

  // A held output freezes the pipeline.
  a_hold_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && !out_pix.ready |=> vld_r == $past(vld_r))
    else $error("pipeline moved during stall");

endmodule
